FILE: hw/rtl/odo_pkg.sv
package odo_pkg;

	localparam int MOTORS_PER_SIDE_DEF = 4;
	localparam int TRIG_STEPS_DEF      = 24;
	localparam int FIELDS_PER_SIDE     = 4;

	localparam int ANGLE_W   = 32;
	localparam int POS_W     = 48;
	localparam int HEAD_W    = 32;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTORS = 2'd0,
		REG_GEAR   = 2'd1,
		REG_TRACK  = 2'd2
	} odo_reg_t;

	// Q30 angle constants
	localparam logic [32:0]        TWO_PI_Q30 = 33'd6746518852;
	localparam logic signed [34:0] Z_TWO_PI   = 35'sd6746518852;
	localparam logic signed [34:0] Z_PI       = 35'sd3373259426;
	localparam logic signed [34:0] Z_HALF_PI  = 35'sd1686629713;
	localparam logic signed [33:0] CORDIC_X0  = 34'sd652032874;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd31: v = 30'd0;
			default: v = 30'd1 << (5'd30 - idx);
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > 64'sd140737488355327)
			r = 48'sh7FFFFFFFFFFF;
		else if (v < -64'sd140737488355328)
			r = 48'sh800000000000;
		else
			r = v[47:0];
		return r;
	endfunction

endpackage

FILE: hw/rtl/odo_sample_if.sv
interface odo_sample_if;
	logic valid;
	logic ready;
	logic signed [odo_pkg::ANGLE_W-1:0] left_angle_0;
	logic signed [odo_pkg::ANGLE_W-1:0] left_angle_1;
	logic signed [odo_pkg::ANGLE_W-1:0] left_angle_2;
	logic signed [odo_pkg::ANGLE_W-1:0] left_angle_3;
	logic signed [odo_pkg::ANGLE_W-1:0] right_angle_0;
	logic signed [odo_pkg::ANGLE_W-1:0] right_angle_1;
	logic signed [odo_pkg::ANGLE_W-1:0] right_angle_2;
	logic signed [odo_pkg::ANGLE_W-1:0] right_angle_3;

	modport source(output valid, left_angle_0, left_angle_1, left_angle_2, left_angle_3,
		right_angle_0, right_angle_1, right_angle_2, right_angle_3, input ready);
	modport sink(input valid, left_angle_0, left_angle_1, left_angle_2, left_angle_3,
		right_angle_0, right_angle_1, right_angle_2, right_angle_3, output ready);
endinterface

FILE: hw/rtl/odo_pose_if.sv
interface odo_pose_if;
	logic valid;
	logic ready;
	logic signed [odo_pkg::POS_W-1:0]  pose_x;
	logic signed [odo_pkg::POS_W-1:0]  pose_y;
	logic signed [odo_pkg::HEAD_W-1:0] heading;

	modport source(output valid, pose_x, pose_y, heading, input ready);
	modport sink(input valid, pose_x, pose_y, heading, output ready);
endinterface

FILE: hw/rtl/differential_drive_odometry.sv
// Channel   Dir  Payload                                      Transfer
// sample    in   left_angle_0..3, right_angle_0..3 (Q24.8)    valid & ready
// pose      out  pose_x, pose_y (Q40.8), heading (Q8.24)      valid & ready
// cfg       in   cfg_index, cfg_data                          cfg_we
//
// A shared restoring divider (one quotient bit per cycle) serves the two side means,
// the heading change and the turn radius; each angle is folded by 2*pi in seven
// compare-subtract steps on the same divider, the CORDIC runs up to TRIG_STEPS
// rotation steps per angle and one 32x32 multiplier serves all products.
// sample.ready is high only while idle; a new pose waits in the output step until
// the previous pose transfers. arst_n clears the pose and the side history and
// sets the registers to their defaults.
module differential_drive_odometry #(
	parameter int MOTORS_PER_SIDE = odo_pkg::MOTORS_PER_SIDE_DEF,
	parameter int TRIG_STEPS      = odo_pkg::TRIG_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [odo_pkg::CFG_W-1:0]     cfg_data,
	odo_sample_if.sink                    sample,
	odo_pose_if.source                    pose
);

	localparam int NF    = (MOTORS_PER_SIDE < odo_pkg::FIELDS_PER_SIDE) ?
		MOTORS_PER_SIDE : odo_pkg::FIELDS_PER_SIDE;
	localparam int STEPS = (TRIG_STEPS > 32) ? 32 : TRIG_STEPS;
	localparam int DVD_W = 57;

	typedef enum logic [3:0] {
		S_IDLE, S_SUM, S_MUL, S_POS, S_DTH, S_HALF, S_RAD, S_RED, S_COR,
		S_MHI, S_MLO, S_OUT
	} state_t;

	typedef enum logic [1:0] {MS_CHORD, MS_X, MS_Y} mstep_t;

	state_t state_q;
	mstep_t mstep_q;

	logic [2:0]  motors_q;
	logic [23:0] gear_q, track_q;

	logic signed [31:0] ang_q [2][NF];
	logic signed [31:0] in_l [odo_pkg::FIELDS_PER_SIDE];
	logic signed [31:0] in_r [odo_pkg::FIELDS_PER_SIDE];
	logic [2:0]  n_q;
	logic        side_q;
	logic        sgn_q, tsel_q, flip_q, out_valid_q;

	logic [32:0]       div_rem_q, div_den_q;
	logic [DVD_W-1:0]  div_quo_q;
	logic [5:0]        div_cnt_q;

	logic [63:0]        prod_q, macc_q;
	logic signed [31:0] pl_q, prev_l_q, prev_r_q, dth_q, half_q;
	logic signed [32:0] dl_q, dr_q, mid_q;
	logic signed [61:0] ma_q, chord_q, px_q, py_q;
	logic signed [33:0] mb_q, s_q, cx_q, cy_q;
	logic signed [34:0] cz_q;
	logic [5:0]         ci_q;
	logic signed [47:0] acc_x_q, acc_y_q;
	logic signed [31:0] acc_h_q;

	// combinational helpers
	logic [2:0]         n_eff;
	logic [23:0]        w_eff;
	logic signed [33:0] side_sum, sum_mag;
	logic [33:0]        div_sh;
	logic signed [34:0] div_trial;
	logic [55:0]        p_up;
	logic signed [40:0] scaled;
	logic signed [31:0] pos_new;
	logic signed [32:0] dl_n, dr_n;
	logic signed [33:0] diff, diff_mag;
	logic signed [57:0] qs;
	logic signed [31:0] dth_n, half_n;
	logic signed [32:0] hsum, mid_n, mid_mag, dl_mag, half_mag;
	logic [32:0]        midq_mag;
	logic [31:0]        dth_mag;
	logic signed [34:0] z0, z1, z2, z3;
	logic               flip_n;
	logic signed [33:0] ysh, xsh;
	logic signed [34:0] at;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;
	logic [61:0]        ma_mag;
	logic [33:0]        mb_mag;
	logic [63:0]        res_mag;
	logic signed [61:0] res;

	always_comb begin
		for (int i = 0; i < odo_pkg::FIELDS_PER_SIDE; i++) begin
			in_l[i] = '0;
			in_r[i] = '0;
		end
		in_l[0] = sample.left_angle_0;
		in_l[1] = sample.left_angle_1;
		in_l[2] = sample.left_angle_2;
		in_l[3] = sample.left_angle_3;
		in_r[0] = sample.right_angle_0;
		in_r[1] = sample.right_angle_1;
		in_r[2] = sample.right_angle_2;
		in_r[3] = sample.right_angle_3;
	end

	always_comb begin
		if (motors_q == 3'd0)
			n_eff = 3'd1;
		else if (motors_q > 3'(NF))
			n_eff = 3'(NF);
		else
			n_eff = motors_q;
		w_eff = (track_q == 24'd0) ? 24'd1 : track_q;

		side_sum = '0;
		for (int i = 0; i < NF; i++) begin
			if (3'(i) < n_q)
				side_sum = side_sum + 34'(ang_q[side_q][i]);
		end
		sum_mag = side_sum[33] ? -side_sum : side_sum;

		div_sh    = {div_rem_q, div_quo_q[DVD_W-1]};
		div_trial = $signed({1'b0, div_sh}) - $signed({2'b0, div_den_q});

		// floor of signed mean times gear over 2^16
		p_up    = prod_q[55:0] + 56'd65535;
		scaled  = sgn_q ? -$signed({1'b0, p_up[55:16]}) : $signed({1'b0, prod_q[55:16]});
		pos_new = odo_pkg::sat32(64'(scaled));

		dl_n     = 33'(pl_q) - 33'(prev_l_q);
		dr_n     = 33'(pos_new) - 33'(prev_r_q);
		diff     = 34'(dr_q) - 34'(dl_q);
		diff_mag = diff[33] ? -diff : diff;

		qs     = sgn_q ? -$signed({1'b0, div_quo_q}) : $signed({1'b0, div_quo_q});
		dth_n  = odo_pkg::sat32(64'(qs));
		hsum   = 33'(dth_n) + (dth_n[31] ? 33'sd1 : 33'sd0);
		half_n = 32'(hsum >>> 1);
		mid_n  = 33'(acc_h_q) + 33'(half_n);
		mid_mag  = mid_n[32] ? -mid_n : mid_n;
		midq_mag = mid_q[32] ? 33'(-mid_q) : 33'(mid_q);
		dl_mag   = dl_q[32] ? -dl_q : dl_q;
		dth_mag  = dth_n[31] ? 32'(-33'(dth_n)) : 32'(dth_n);
		half_mag = half_q[31] ? -33'(half_q) : 33'(half_q);

		// fold the remainder into [-pi/2, pi/2] with a sign flip
		z0 = sgn_q ? -$signed({2'b0, div_rem_q}) : $signed({2'b0, div_rem_q});
		z1 = (z0 < 0) ? z0 + odo_pkg::Z_TWO_PI : z0;
		z2 = (z1 > odo_pkg::Z_PI) ? z1 - odo_pkg::Z_TWO_PI : z1;
		flip_n = 1'b0;
		z3 = z2;
		if (z2 > odo_pkg::Z_HALF_PI) begin
			z3 = z2 - odo_pkg::Z_PI;
			flip_n = 1'b1;
		end else if (z2 < -odo_pkg::Z_HALF_PI) begin
			z3 = z2 + odo_pkg::Z_PI;
			flip_n = 1'b1;
		end

		ysh = cy_q >>> ci_q[4:0];
		xsh = cx_q >>> ci_q[4:0];
		at  = $signed({5'b0, odo_pkg::atan_q30(ci_q[4:0])});

		ma_mag = ma_q[61] ? 62'(-ma_q) : 62'(ma_q);
		mb_mag = mb_q[33] ? 34'(-mb_q) : 34'(mb_q);
		case (state_q)
			S_MUL: begin
				mul_a = div_quo_q[31:0];
				mul_b = {8'b0, gear_q};
			end
			S_MHI: begin
				mul_a = {2'b0, ma_mag[61:32]};
				mul_b = mb_mag[31:0];
			end
			S_MLO: begin
				mul_a = ma_mag[31:0];
				mul_b = mb_mag[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p   = mul_a * mul_b;
		res_mag = macc_q + (mul_p >> 30);
		res     = (ma_q[61] ^ mb_q[33]) ? -$signed(62'(res_mag)) : $signed(62'(res_mag));
	end

	assign sample.ready = (state_q == S_IDLE);
	assign pose.valid   = out_valid_q;
	assign pose.pose_x  = acc_x_q;
	assign pose.pose_y  = acc_y_q;
	assign pose.heading = acc_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= MS_CHORD;
			motors_q    <= 3'd1;
			gear_q      <= 24'd65536;
			track_q     <= 24'd92160;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_h_q     <= '0;
			side_q      <= 1'b0;
			tsel_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					odo_pkg::REG_MOTORS: motors_q <= cfg_data[2:0];
					odo_pkg::REG_GEAR:   gear_q   <= cfg_data;
					odo_pkg::REG_TRACK:  track_q  <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && pose.ready && state_q != S_OUT)
				out_valid_q <= 1'b0;

			// advance the divider one quotient bit
			if (div_cnt_q != 6'd0) begin
				div_cnt_q <= div_cnt_q - 6'd1;
				if (!div_trial[34]) begin
					div_rem_q <= div_trial[32:0];
					div_quo_q <= {div_quo_q[DVD_W-2:0], 1'b1};
				end else begin
					div_rem_q <= div_sh[32:0];
					div_quo_q <= {div_quo_q[DVD_W-2:0], 1'b0};
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						for (int i = 0; i < NF; i++) begin
							ang_q[0][i] <= in_l[i];
							ang_q[1][i] <= in_r[i];
						end
						n_q     <= n_eff;
						side_q  <= 1'b0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sgn_q     <= side_sum[33];
					div_rem_q <= '0;
					div_quo_q <= {sum_mag, 23'b0};
					div_den_q <= {30'b0, n_q};
					div_cnt_q <= 6'd34;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					if (div_cnt_q == 6'd0) begin
						prod_q  <= mul_p;
						state_q <= S_POS;
					end
				end
				S_POS: begin
					if (!side_q) begin
						pl_q    <= pos_new;
						side_q  <= 1'b1;
						state_q <= S_SUM;
					end else begin
						dl_q      <= dl_n;
						dr_q      <= dr_n;
						prev_l_q  <= pl_q;
						prev_r_q  <= pos_new;
						state_q   <= S_DTH;
					end
				end
				S_DTH: begin
					sgn_q     <= diff[33];
					div_rem_q <= '0;
					div_quo_q <= {diff_mag[32:0], 24'b0};
					div_den_q <= {9'b0, w_eff};
					div_cnt_q <= 6'd57;
					state_q   <= S_HALF;
				end
				S_HALF: begin
					if (div_cnt_q == 6'd0) begin
						dth_q     <= dth_n;
						half_q    <= half_n;
						mid_q     <= mid_n;
						div_rem_q <= '0;
						if (dth_n == 32'sd0) begin
							// straight move: chord is the left travel
							chord_q   <= 62'(dl_q);
							sgn_q     <= mid_n[32];
							tsel_q    <= 1'b1;
							// upper bits stay below 2*pi: start at the last seven steps
							div_rem_q <= {1'b0, mid_mag[32:1]};
							div_quo_q <= {mid_mag[0], 56'b0};
							div_den_q <= odo_pkg::TWO_PI_Q30;
							div_cnt_q <= 6'd7;
							state_q   <= S_RED;
						end else begin
							sgn_q     <= dl_q[32] ^ dth_n[31];
							div_quo_q <= {1'b0, dl_mag[31:0], 24'b0};
							div_den_q <= {1'b0, dth_mag};
							div_cnt_q <= 6'd57;
							state_q   <= S_RAD;
						end
					end
				end
				S_RAD: begin
					if (div_cnt_q == 6'd0) begin
						ma_q      <= 62'(qs) + $signed({39'b0, w_eff[23:1]});
						sgn_q     <= half_q[31];
						tsel_q    <= 1'b0;
						div_rem_q <= {1'b0, half_mag[32:1]};
						div_quo_q <= {half_mag[0], 56'b0};
						div_den_q <= odo_pkg::TWO_PI_Q30;
						div_cnt_q <= 6'd7;
						state_q   <= S_RED;
					end
				end
				S_RED: begin
					if (div_cnt_q == 6'd0) begin
						cz_q    <= z3;
						flip_q  <= flip_n;
						cx_q    <= odo_pkg::CORDIC_X0;
						cy_q    <= '0;
						ci_q    <= '0;
						state_q <= S_COR;
					end
				end
				S_COR: begin
					if (ci_q != 6'(STEPS)) begin
						if (!cz_q[34]) begin
							cx_q <= cx_q - ysh;
							cy_q <= cy_q + xsh;
							cz_q <= cz_q - at;
						end else begin
							cx_q <= cx_q + ysh;
							cy_q <= cy_q - xsh;
							cz_q <= cz_q + at;
						end
						ci_q <= ci_q + 6'd1;
					end else begin
						if (!tsel_q) begin
							mb_q    <= flip_q ? -cy_q : cy_q;
							mstep_q <= MS_CHORD;
						end else begin
							mb_q    <= flip_q ? -cx_q : cx_q;
							s_q     <= flip_q ? -cy_q : cy_q;
							ma_q    <= chord_q;
							mstep_q <= MS_X;
						end
						state_q <= S_MHI;
					end
				end
				S_MHI: begin
					macc_q  <= mul_p << 2;
					state_q <= S_MLO;
				end
				S_MLO: begin
					case (mstep_q)
						MS_CHORD: begin
							chord_q   <= res <<< 1;
							sgn_q     <= mid_q[32];
							tsel_q    <= 1'b1;
							div_rem_q <= {1'b0, midq_mag[32:1]};
							div_quo_q <= {midq_mag[0], 56'b0};
							div_den_q <= odo_pkg::TWO_PI_Q30;
							div_cnt_q <= 6'd7;
							state_q   <= S_RED;
						end
						MS_X: begin
							px_q    <= res;
							ma_q    <= chord_q;
							mb_q    <= s_q;
							mstep_q <= MS_Y;
							state_q <= S_MHI;
						end
						default: begin
							py_q    <= res;
							state_q <= S_OUT;
						end
					endcase
				end
				S_OUT: begin
					// hold until the previous pose has transferred
					if (!out_valid_q || pose.ready) begin
						acc_x_q     <= odo_pkg::sat48(64'(acc_x_q) + 64'(px_q));
						acc_y_q     <= odo_pkg::sat48(64'(acc_y_q) + 64'(py_q));
						acc_h_q     <= odo_pkg::sat32(64'(acc_h_q) + 64'(dth_q));
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample taken while a sample is in work");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(div_cnt_q != 6'd0) |-> (state_q == S_MUL || state_q == S_HALF ||
			state_q == S_RAD || state_q == S_RED))
		else $error("divider running outside a wait state");

	a_pose_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose.valid) |-> $past(state_q) == S_OUT)
		else $error("pose valid raised outside the output step");

	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COR) |-> (ci_q <= 6'(STEPS)))
		else $error("CORDIC step count overran");

endmodule
